// File: hw/rtl/joe_pkg.sv
// Shared types and constants for the Josephus elimination order core.
// No dependencies.
package joe_pkg;

  localparam int PLAYER_W = 7;
  localparam int STEP_W   = 8;

  typedef logic [PLAYER_W-1:0] player_t;
  typedef logic [STEP_W-1:0]   step_t;

  // Result word offered by the sequencer to the output stage.
  typedef struct packed {
    logic    valid;
    player_t player;
    logic    survivor;
  } res_t;

endpackage

// File: hw/rtl/joe_succ_ram.sv
// Successor table: one write port, one read port with registered read data.
// No dependencies.
module joe_succ_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/joe_ctrl.sv
// Run sequencer: builds the circle, walks links one per cycle, unlinks players.
// Depends on joe_pkg and joe_succ_ram.
module joe_ctrl #(
  parameter int MAX_PLAYERS = 64,
  parameter int IW          = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  joe_pkg::player_t player_count,
  input  joe_pkg::step_t   step_interval,
  output joe_pkg::res_t    res,
  input  logic             res_ready
);
  import joe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_WSTART, ST_WALK, ST_REMOVE, ST_SURV
  } state_t;

  state_t        state;
  player_t       n;
  step_t         step;
  step_t         cnt;
  player_t       remaining;
  logic [IW-1:0] idx;
  logic [IW-1:0] cur;
  logic [IW-1:0] prev;
  logic [IW-1:0] n_last;

  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] wdata;
  logic          re;
  logic [IW-1:0] raddr;
  logic [IW-1:0] rdata;
  logic          res_fire;
  player_t       n_sat;

  joe_succ_ram #(.DEPTH(MAX_PLAYERS), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign n_last   = IW'(n - player_t'(1));
  assign in_ready = (state == ST_IDLE);
  assign res_fire = res.valid && res_ready;

  always_comb begin
    if (player_count == '0) begin
      n_sat = player_t'(1);
    end else if (player_count > player_t'(MAX_PLAYERS)) begin
      n_sat = player_t'(MAX_PLAYERS);
    end else begin
      n_sat = player_count;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = (idx == n_last) ? '0 : idx + IW'(1);
    re    = 1'b0;
    raddr = cur;
    unique case (state)
      ST_INIT: begin
        we = 1'b1;
      end
      ST_WSTART: begin
        re = 1'b1;
      end
      ST_WALK: begin
        re    = 1'b1;
        raddr = rdata;
      end
      ST_REMOVE: begin
        we    = res_ready;
        waddr = prev;
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.valid    = (state == ST_REMOVE) || (state == ST_SURV);
    res.player   = player_t'(cur) + player_t'(1);
    res.survivor = (state == ST_SURV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remaining <= '0;
      cur       <= '0;
      prev      <= '0;
      idx       <= '0;
      cnt       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            n     <= n_sat;
            step  <= (step_interval == '0) ? step_t'(1) : step_interval;
            idx   <= '0;
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          idx <= idx + IW'(1);
          if (idx == n_last) begin
            cur       <= n_last;
            prev      <= n_last;
            remaining <= n;
            state     <= (n == player_t'(1)) ? ST_SURV : ST_WSTART;
          end
        end
        ST_WSTART: begin
          prev  <= cur;
          cnt   <= step_t'(1);
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (cnt == step) begin
            cur   <= rdata;
            state <= ST_REMOVE;
          end else begin
            prev <= rdata;
            cnt  <= cnt + step_t'(1);
          end
        end
        ST_REMOVE: begin
          if (res_ready) begin
            cur       <= prev;
            remaining <= remaining - player_t'(1);
            state     <= (remaining == player_t'(2)) ? ST_SURV : ST_WSTART;
          end
        end
        ST_SURV: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_remaining_bound: assert property (@(posedge clk) disable iff (rst)
    remaining <= player_t'(MAX_PLAYERS))
    else $error("remaining count above table depth");

  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (cnt != '0 && cnt <= step))
    else $error("link count out of range");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    (res_fire && !res.survivor) |=> (remaining == $past(remaining) - player_t'(1)))
    else $error("remaining count not decremented on elimination");

  a_survivor_ends: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res.survivor) |=> (state == ST_IDLE))
    else $error("run did not end after survivor");

  a_remove_min: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REMOVE) |-> (remaining > player_t'(1)))
    else $error("elimination with a single player left");
`endif

endmodule

// File: hw/rtl/josephus_elimination_order_core.sv
// Top level of the Josephus elimination order core: sequencer plus output register.
// Depends on joe_pkg and joe_ctrl.
//
//  channel  | handshake            | word
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_ready  | player_count, step_interval
//  output   | out_valid / out_ready| player_number, is_survivor, last
//
// A run of n players (n clamped to 1..MAX_PLAYERS, step s clamped to >= 1)
// walks one successor link per cycle, set by the single read port of the
// successor table.
// in_ready is high only between runs. Output stalls hold the sequencer.
// Reset is synchronous; the successor table is rebuilt at the start of each run.
module josephus_elimination_order_core #(
  parameter int MAX_PLAYERS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  joe_pkg::player_t player_count,
  input  joe_pkg::step_t   step_interval,
  output logic             out_valid,
  input  logic             out_ready,
  output joe_pkg::player_t player_number,
  output logic             is_survivor,
  output logic             last
);
  import joe_pkg::*;

  localparam int IW = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;

  res_t res;
  logic res_ready;

  assign res_ready = !out_valid || out_ready;

  joe_ctrl #(.MAX_PLAYERS(MAX_PLAYERS), .IW(IW)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .player_count  (player_count),
    .step_interval (step_interval),
    .res           (res),
    .res_ready     (res_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      player_number <= res.player;
      is_survivor   <= res.survivor;
      last          <= res.survivor;
    end
  end

endmodule

// File: verif/tb_josephus_elimination_order_core.sv
`timescale 1ns / 100ps
// Testbench for josephus_elimination_order_core: sends runs of (player count, step interval),
// predicts each elimination word with a successor-ring model and checks every output word.
// Depends on joe_pkg and the core RTL.
module tb_josephus_elimination_order_core;
  import joe_pkg::*;

  localparam int MAX_PLAYERS  = 64;
  localparam int LIMIT_CYCLES = 10_000_000;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 32;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    player_t player;
    logic    survivor;
    logic    is_last;
  } elim_word_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  player_t player_count = '0;
  step_t   step_interval = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  player_t player_number;
  logic    is_survivor;
  logic    last;

  elim_word_t  expected_order[$];
  elim_word_t  exp_word;
  logic [5:0]  ring_next [MAX_PLAYERS];
  logic [5:0]  ring_pos;
  logic [5:0]  ring_prev;
  logic [6:0]  ring_left;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          tx_gaps_on = 1'b1;
  rx_mode_t    rx_mode = RX_FREE;
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [3:0]  rx_phase = '0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  josephus_elimination_order_core #(
    .MAX_PLAYERS(MAX_PLAYERS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .player_count (player_count),
    .step_interval(step_interval),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .player_number(player_number),
    .is_survivor  (is_survivor),
    .last         (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Ring model: appends the full elimination order of one run.
  function automatic void predict_elimination_order(input player_t cnt, input step_t stp);
    int unsigned n;
    int unsigned s;
    int unsigned i;
    int unsigned j;
    elim_word_t  w;
    n = cnt;
    if (n < 1) n = 1;
    if (n > MAX_PLAYERS) n = MAX_PLAYERS;
    s = stp;
    if (s < 1) s = 1;
    for (i = 0; i < n; i++) ring_next[i] = 6'((i + 1) % n);
    ring_pos  = 6'(n - 1);
    ring_prev = ring_pos;
    ring_left = 7'(n);
    while (ring_left > 1) begin
      for (j = 0; j < s; j++) begin
        ring_prev = ring_pos;
        ring_pos  = ring_next[ring_pos];
      end
      w.player   = {1'b0, ring_pos} + 7'd1;
      w.survivor = 1'b0;
      w.is_last  = 1'b0;
      expected_order.push_back(w);
      ring_next[ring_prev] = ring_next[ring_pos];
      ring_pos  = ring_prev;
      ring_left = ring_left - 7'd1;
    end
    w.player   = {1'b0, ring_pos} + 7'd1;
    w.survivor = 1'b1;
    w.is_last  = 1'b1;
    expected_order.push_back(w);
  endfunction

  task automatic send_run(input player_t cnt, input step_t stp);
    @(negedge clk);
    if (burst_left == 0) begin
      if (tx_gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 6);
    end
    in_valid      <= 1'b1;
    player_count  <= cnt;
    step_interval <= stp;
    burst_left--;
    do @(posedge clk); while (!in_ready);
    predict_elimination_order(cnt, stp);
  endtask

  // receiver: long hold-off on request, otherwise the current stall mode
  always @(negedge clk) begin
    rx_phase <= rx_phase + 4'd1;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
    end else begin
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= rx_pattern[rx_phase];
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_order.size() == 0) begin
        if (mismatch_count < 10)
          $display("[%0t] unexpected word: player %0d survivor %b last %b",
                   $time, player_number, is_survivor, last);
        mismatch_count++;
      end else begin
        exp_word = expected_order.pop_front();
        if (player_number !== exp_word.player || is_survivor !== exp_word.survivor ||
            last !== exp_word.is_last) begin
          if (mismatch_count < 10)
            $display("[%0t] mismatch: exp player %0d survivor %b last %b, got %0d %b %b",
                     $time, exp_word.player, exp_word.survivor, exp_word.is_last,
                     player_number, is_survivor, last);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed_extremes();
    rx_mode    = RX_FREE;
    tx_gaps_on = 1'b0;
    send_run(7'd1, 8'd1);
    send_run(7'd2, 8'd1);
    send_run(7'd2, 8'd2);
    send_run(7'd7, 8'd3);
    send_run(7'd41, 8'd3);
    send_run(7'd64, 8'd1);
    send_run(7'd64, 8'd2);
    send_run(7'd1, 8'd255);
    send_run(7'd2, 8'd255);
    send_run(7'd64, 8'd255);
  endtask

  // zero count, zero step, counts above the ring size
  task automatic test_special_cases();
    rx_mode    = RX_RANDOM;
    tx_gaps_on = 1'b1;
    send_run(7'd0, 8'd5);
    send_run(7'd0, 8'd0);
    send_run(7'd10, 8'd0);
    send_run(7'd65, 8'd2);
    send_run(7'd127, 8'd7);
    send_run(7'd100, 8'd0);
    send_run(7'd127, 8'd255);
  endtask

  task automatic test_output_hold_off();
    rx_pattern = 16'($urandom) | 16'h0001;
    rx_mode    = RX_PATTERN;
    tx_gaps_on = 1'b0;
    hold_req   = 1'b1;
    send_run(7'd12, 8'd3);
    send_run(7'd5, 8'd9);
    send_run(7'd20, 8'd1);
    send_run(7'd3, 8'd200);
  endtask

  task automatic test_random_runs(input int unsigned num_runs);
    int unsigned k;
    int unsigned sel;
    player_t     cnt;
    step_t       stp;
    for (k = 0; k < num_runs; k++) begin
      if (k % 20 == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 2));
        rx_pattern = 16'($urandom) | 16'h0001;
        tx_gaps_on = ($urandom_range(0, 2) != 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        cnt = 7'($urandom_range(1, 16));
        stp = 8'($urandom_range(1, 24));
      end else if (sel < 85) begin
        cnt = 7'($urandom_range(17, 64));
        stp = 8'($urandom_range(1, 40));
      end else if (sel < 93) begin
        cnt = 7'($urandom_range(0, 127));
        stp = 8'($urandom_range(0, 255));
      end else begin
        cnt = 7'($urandom_range(1, 12));
        stp = 8'($urandom_range(100, 255));
      end
      send_run(cnt, stp);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_special_cases();
    test_output_hold_off();
    test_random_runs(80);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_order.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/joe_pkg.sv
hw/rtl/joe_succ_ram.sv
hw/rtl/joe_ctrl.sv
hw/rtl/josephus_elimination_order_core.sv
verif/tb_josephus_elimination_order_core.sv
